>>> design/sacm_pkg.sv
// ----------------------------------------------------------------------------
// sacm_pkg: shared definitions
// Default geometry, configuration register indexes and count helpers for the
// set-associative cache model.
// ----------------------------------------------------------------------------
`default_nettype none
package sacm_pkg;
	localparam int unsigned DEF_MAX_SETS    = 256;
	localparam int unsigned DEF_MAX_WAYS    = 8;
	localparam int unsigned DEF_BLOCK_BYTES = 64;
	localparam int unsigned DEF_ADDR_BITS   = 48;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;
	localparam int unsigned CNT_W      = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPLACE_FIFO = 2'd0,
		REG_WRITE_BACK   = 2'd1,
		REG_WAYS_IN_USE  = 2'd2,
		REG_SETS_LOG2    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic hit;
		logic mem_read;
		logic mem_write;
	} access_flags_t;

	function automatic count_t sat_inc(input count_t c, input logic en);
		sat_inc = (en && (c != '1)) ? c + count_t'(1) : c;
	endfunction
endpackage
`default_nettype wire

>>> design/set_assoc_cache_model_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_model_core: set-associative cache model
// Looks up one access per transaction, updates the set row and reports flags
// and running counts.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// access    start / busy        operation, address
// result    done (one cycle)    hit, mem_read, mem_write, four totals
// config    cfg_we              cfg_index, cfg_data
//
// The set row is read from the row memory in the accept cycle and written back
// in the next, where busy is high. The result strobe follows in the cycle after
// the write-back. No clearing pass is needed: a flip-flop per set marks rows
// never written, which read as empty. The receiver cannot stall.
`default_nettype none
module set_assoc_cache_model_core #(
	parameter int unsigned MAX_SETS    = sacm_pkg::DEF_MAX_SETS,
	parameter int unsigned MAX_WAYS    = sacm_pkg::DEF_MAX_WAYS,
	parameter int unsigned BLOCK_BYTES = sacm_pkg::DEF_BLOCK_BYTES,
	parameter int unsigned ADDR_BITS   = sacm_pkg::DEF_ADDR_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            operation,
	input  wire logic [ADDR_BITS-1:0]            address,
	output logic                                 done,
	output logic                                 hit,
	output logic                                 mem_read,
	output logic                                 mem_write,
	output sacm_pkg::count_t                     hit_total,
	output sacm_pkg::count_t                     miss_total,
	output sacm_pkg::count_t                     read_total,
	output sacm_pkg::count_t                     write_total,
	input  wire logic                            cfg_we,
	input  wire logic [sacm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sacm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sacm_pkg::*;

	localparam int unsigned OFS_W  = $clog2(BLOCK_BYTES);
	localparam int unsigned TAG_W  = ADDR_BITS - OFS_W;
	localparam int unsigned SMAX   = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned SW     = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
	localparam int unsigned AGE_W  = $clog2(MAX_WAYS > 1 ? MAX_WAYS : 2);
	localparam int unsigned NW     = $clog2(MAX_WAYS + 1);
	localparam int unsigned ROW_W  = MAX_WAYS * (TAG_W + 2 + AGE_W) + AGE_W;

	logic                    fifo_q, wb_q;
	logic [CFG_DATA_W-1:0]   ways_q, sets_q;
	logic [4:0]              sl;
	logic [NW-1:0]           n_ways;
	logic [SW-1:0]           set_mask, set_in;
	logic                    accept;

	logic                    busy_s1;
	logic                    op_s1;
	logic [TAG_W-1:0]        block_s1;
	logic [SW-1:0]           set_s1;
	logic                    rv_s1;
	logic [MAX_SETS-1:0]     row_valid_q;

	logic [ROW_W-1:0]        rd_row, wr_row;
	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_r, tag_w;
	logic [MAX_WAYS-1:0]            val_r, val_w, dty_r, dty_w;
	logic [MAX_WAYS-1:0][AGE_W-1:0] age_r, age_w;
	logic [AGE_W-1:0]               fp_r, fp_w;
	access_flags_t                  flags;

	assign accept = start && !busy_s1;
	assign busy   = busy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_q <= 1'b0;
			wb_q   <= 1'b0;
			ways_q <= CFG_DATA_W'(1);
			sets_q <= CFG_DATA_W'(8);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REPLACE_FIFO: fifo_q <= cfg_data[0];
				REG_WRITE_BACK:   wb_q   <= cfg_data[0];
				REG_WAYS_IN_USE:  ways_q <= cfg_data;
				REG_SETS_LOG2:    sets_q <= cfg_data;
				default:          fifo_q <= fifo_q;
			endcase
		end
	end

	always_comb begin
		sl = ({1'b0, sets_q} > 5'(SMAX)) ? 5'(SMAX) : {1'b0, sets_q};
		for (int i = 0; i < SW; i++) begin
			set_mask[i] = (5'(i) < sl);
		end
		if (ways_q == '0) begin
			n_ways = NW'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			n_ways = NW'(MAX_WAYS);
		end else begin
			n_ways = NW'(ways_q);
		end
		set_in = address[OFS_W +: SW] & set_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			row_valid_q <= '0;
		end else begin
			busy_s1 <= accept;
			if (busy_s1) begin
				row_valid_q[set_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			block_s1 <= address[ADDR_BITS-1:OFS_W];
			set_s1   <= set_in;
			rv_s1    <= row_valid_q[set_in];
		end
	end

	// The row of the next access is read only after this one is written back,
	// so no forwarding path is needed.
	sacm_row_ram #(.DEPTH(MAX_SETS), .WIDTH(ROW_W)) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (set_in),
		.rd_data (rd_row),
		.wr_en   (busy_s1),
		.wr_addr (set_s1),
		.wr_data (wr_row)
	);

	always_comb begin
		{tag_r, val_r, dty_r, age_r, fp_r} = rd_row;
		if (!rv_s1) begin
			val_r = '0;
			dty_r = '0;
			age_r = '0;
			fp_r  = '0;
		end
		wr_row = {tag_w, val_w, dty_w, age_w, fp_w};
	end

	sacm_update #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W), .AGE_W(AGE_W), .NW(NW)) u_upd (
		.is_write     (op_s1),
		.write_back   (wb_q),
		.replace_fifo (fifo_q),
		.n_ways       (n_ways),
		.block        (block_s1),
		.tag_in       (tag_r),
		.valid_in     (val_r),
		.dirty_in     (dty_r),
		.age_in       (age_r),
		.fptr_in      (fp_r),
		.tag_out      (tag_w),
		.valid_out    (val_w),
		.dirty_out    (dty_w),
		.age_out      (age_w),
		.fptr_out     (fp_w),
		.flags        (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			hit_total   <= '0;
			miss_total  <= '0;
			read_total  <= '0;
			write_total <= '0;
		end else begin
			done <= busy_s1;
			if (busy_s1) begin
				hit_total   <= sat_inc(hit_total, flags.hit);
				miss_total  <= sat_inc(miss_total, !flags.hit);
				read_total  <= sat_inc(read_total, flags.mem_read);
				write_total <= sat_inc(write_total, flags.mem_write);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			hit       <= flags.hit;
			mem_read  <= flags.mem_read;
			mem_write <= flags.mem_write;
		end
	end
endmodule
`default_nettype wire

>>> design/sacm_row_ram.sv
// ----------------------------------------------------------------------------
// sacm_row_ram: set row memory
// One row per set, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sacm_row_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic                            clk,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                rd_data,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> design/sacm_update.sv
// ----------------------------------------------------------------------------
// sacm_update: lookup and row update
// Tag compare, victim choice, LRU aging and dirty tracking for one set row.
// ----------------------------------------------------------------------------
`default_nettype none
module sacm_update #(
	parameter int unsigned MAX_WAYS = 8,
	parameter int unsigned TAG_W    = 42,
	parameter int unsigned AGE_W    = 3,
	parameter int unsigned NW       = 4
) (
	input  wire logic                              is_write,
	input  wire logic                              write_back,
	input  wire logic                              replace_fifo,
	input  wire logic [NW-1:0]                     n_ways,
	input  wire logic [TAG_W-1:0]                  block,
	input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_in,
	input  wire logic [MAX_WAYS-1:0]               valid_in,
	input  wire logic [MAX_WAYS-1:0]               dirty_in,
	input  wire logic [MAX_WAYS-1:0][AGE_W-1:0]    age_in,
	input  wire logic [AGE_W-1:0]                  fptr_in,
	output logic      [MAX_WAYS-1:0][TAG_W-1:0]    tag_out,
	output logic      [MAX_WAYS-1:0]               valid_out,
	output logic      [MAX_WAYS-1:0]               dirty_out,
	output logic      [MAX_WAYS-1:0][AGE_W-1:0]    age_out,
	output logic      [AGE_W-1:0]                  fptr_out,
	output sacm_pkg::access_flags_t                flags
);
	import sacm_pkg::*;

	localparam logic [AGE_W:0] AGE_EMPTY = (AGE_W+1)'(MAX_WAYS);
	localparam logic [AGE_W:0] AGE_SAT   = (AGE_W+1)'(MAX_WAYS - 1);

	logic             hit, found, alloc, touch;
	logic [AGE_W-1:0] hway, eway, lway, fway, fnext, way;
	logic [AGE_W-1:0] best;
	logic [AGE_W:0]   old_age;

	always_comb begin
		hit = 1'b0;
		hway = '0;
		found = 1'b0;
		eway = '0;
		best = '0;
		lway = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (NW'(i) < n_ways && valid_in[i] && tag_in[i] == block) begin
				hit = 1'b1;
				hway = AGE_W'(i);
			end
			if (NW'(i) < n_ways && !valid_in[i]) begin
				found = 1'b1;
				eway = AGE_W'(i);
			end
		end
		// Strictly greater keeps the lowest index on a tie.
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (NW'(i) < n_ways && age_in[i] > best) begin
				best = age_in[i];
				lway = AGE_W'(i);
			end
		end
	end

	always_comb begin
		fway  = (NW'(fptr_in) < n_ways) ? fptr_in : '0;
		fnext = (NW'(fway) + NW'(1) == n_ways) ? '0 : fway + AGE_W'(1);
	end

	always_comb begin
		alloc = !hit && !(is_write && !write_back);
		if (hit) begin
			way = hway;
		end else if (found) begin
			way = eway;
		end else if (replace_fifo) begin
			way = fway;
		end else begin
			way = lway;
		end
		touch   = !replace_fifo && (hit || alloc);
		old_age = valid_in[way] ? {1'b0, age_in[way]} : AGE_EMPTY;

		tag_out   = tag_in;
		valid_out = valid_in;
		dirty_out = dirty_in;
		age_out   = age_in;
		fptr_out  = fptr_in;
		flags.hit       = hit;
		flags.mem_read  = alloc;
		flags.mem_write = is_write && !write_back;

		if (touch) begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (NW'(i) < n_ways && AGE_W'(i) != way && valid_in[i] &&
				    {1'b0, age_in[i]} < old_age && {1'b0, age_in[i]} < AGE_SAT) begin
					age_out[i] = age_in[i] + AGE_W'(1);
				end
			end
			age_out[way] = '0;
		end
		if (hit && is_write && write_back) begin
			dirty_out[way] = 1'b1;
		end
		if (alloc) begin
			tag_out[way]   = block;
			valid_out[way] = 1'b1;
			dirty_out[way] = is_write;
			if (!found) begin
				if (dirty_in[way]) begin
					flags.mem_write = 1'b1;
				end
				if (replace_fifo) begin
					fptr_out = fnext;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> design/sacm_chk.sv
// ----------------------------------------------------------------------------
// sacm_chk: port checker
// Timing and result consistency checks on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module sacm_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic             hit,
	input wire logic             mem_read,
	input wire sacm_pkg::count_t hit_total
);
	import sacm_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");

	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done) else $error("result strobe missing");

	a_no_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy overlaps the result strobe");

	a_hit_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && mem_read)) else $error("hit with a memory read");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> hit_total != '0) else $error("hit not counted");
endmodule

bind set_assoc_cache_model_core sacm_chk u_sacm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.hit       (hit),
	.mem_read  (mem_read),
	.hit_total (hit_total)
);
`default_nettype wire
